// File: hw/rtl/dhkv_pkg.sv
`default_nettype none

package dhkv_pkg;

    // payload widths
    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 3;

    // result codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // request codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/dhkv_rem.sv
`default_nettype none

// remainder unit: key mod SLOT_COUNT and key mod (SLOT_COUNT - 1) by reciprocal
// multiplication, one shared 32 x 32 multiplier used over four steps
module dhkv_rem #(
    parameter int SLOT_COUNT = 101,
    parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [dhkv_pkg::KEY_W-1:0] key,
    output logic                          done,
    output logic [IDX_W-1:0]              rem_first,
    output logic [IDX_W-1:0]              rem_stride
);

    localparam int MUL_W   = 32;
    localparam int KEY_W   = dhkv_pkg::KEY_W;
    localparam int DIV_A   = SLOT_COUNT;
    localparam int DIV_B   = SLOT_COUNT - 1;

    // rounded-up reciprocal with this shift gives the exact quotient of any key
    localparam int SHIFT_A = KEY_W + $clog2(DIV_A);
    localparam int SHIFT_B = KEY_W + $clog2(DIV_B);
    localparam logic [MUL_W-1:0] RECIP_A =
        MUL_W'(((64'd1 << SHIFT_A) + 64'(DIV_A) - 64'd1) / 64'(DIV_A));
    localparam logic [MUL_W-1:0] RECIP_B =
        MUL_W'(((64'd1 << SHIFT_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B));
    localparam logic [MUL_W-1:0] DIV_A_W = MUL_W'(DIV_A);
    localparam logic [MUL_W-1:0] DIV_B_W = MUL_W'(DIV_B);

    // multiplier steps
    localparam logic [1:0] STEP_QA = 2'd0;
    localparam logic [1:0] STEP_RA = 2'd1;
    localparam logic [1:0] STEP_QB = 2'd2;
    localparam logic [1:0] STEP_RB = 2'd3;

    logic                    busy_reg,   busy_next;
    logic                    done_reg,   done_next;
    logic [1:0]              step_reg,   step_next;
    logic [KEY_W-1:0]        key_reg,    key_next;
    logic [KEY_W-1:0]        quo_reg,    quo_next;
    logic [IDX_W-1:0]        ra_reg,     ra_next;
    logic [IDX_W-1:0]        rb_reg,     rb_next;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [2*MUL_W-1:0]      mul_p;
    logic [KEY_W-1:0]        rem_w;

    // quotient steps take the key, remainder steps take the quotient
    assign mul_a = step_reg[0] ? MUL_W'(quo_reg) : MUL_W'(key_reg);

    always_comb
    begin
        case (step_reg)
            STEP_QA: mul_b = RECIP_A;
            STEP_RA: mul_b = DIV_A_W;
            STEP_QB: mul_b = RECIP_B;
            STEP_RB: mul_b = DIV_B_W;
            default: mul_b = RECIP_A;
        endcase
    end

    assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

    // quotient times divisor never exceeds the key
    assign rem_w = key_reg - KEY_W'(mul_p);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        key_next  = key_reg;
        quo_next  = quo_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_QA;
            key_next  = key;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 1'b1;
            case (step_reg)
                STEP_QA: quo_next = KEY_W'(mul_p >> SHIFT_A);
                STEP_RA: ra_next  = IDX_W'(rem_w);
                STEP_QB: quo_next = KEY_W'(mul_p >> SHIFT_B);
                STEP_RB:
                begin
                    rb_next   = IDX_W'(rem_w);
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: step_next = STEP_QA;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_QA;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        quo_reg <= quo_next;
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
    end

    assign done       = done_reg;
    assign rem_first  = ra_reg;
    assign rem_stride = rb_reg;

endmodule

`default_nettype wire

// File: hw/rtl/double_hash_key_value_table_top.sv
`default_nettype none

// channel  | handshake           | words
// ---------+---------------------+------------------------------
// request  | req_valid/req_stall | action, key, value_in
// response | rsp_valid/rsp_stall | status, value_out
//
// one request at a time; req_stall is high from acceptance until the result
// has been moved into the response register
// each request passes from acceptance through a reciprocal-multiply mod in the
// shared remainder unit, a read and a check of slot memory per probe, a load of
// the response register and a return to idle; an insert into a table at
// capacity skips hashing and probing and goes straight to the response register
// reset: a clearing pass over all SLOT_COUNT slots wipes the used bits in slot
// memory; requests are stalled during it
// the response register holds its word while rsp_stall is high; a new request
// can be taken meanwhile and waits at the end for the register to free up
module double_hash_key_value_table_top #(
    parameter int SLOT_COUNT = 101
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic                           action,
    input  wire logic [dhkv_pkg::KEY_W-1:0]     key,
    input  wire logic [dhkv_pkg::VALUE_W-1:0]   value_in,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output logic [dhkv_pkg::STATUS_W-1:0]       status,
    output logic [dhkv_pkg::VALUE_W-1:0]        value_out
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int KEY_W = dhkv_pkg::KEY_W;
    localparam int VAL_W = dhkv_pkg::VALUE_W;
    localparam int ST_W  = dhkv_pkg::STATUS_W;

    localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(SLOT_COUNT);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOT_COUNT - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg,   state_next;
    logic [IDX_W-1:0]  idx_reg,     idx_next;
    logic [IDX_W-1:0]  stride_reg,  stride_next;
    logic [CNT_W-1:0]  probe_reg,   probe_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              act_reg,     act_next;
    logic [KEY_W-1:0]  key_reg,     key_next;
    logic [VAL_W-1:0]  val_reg,     val_next;
    logic [ST_W-1:0]   res_st_reg,  res_st_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ST_W-1:0]   status_reg,  status_next;
    logic [VAL_W-1:0]  value_out_reg, value_out_next;

    // slot memories: used bit sits on top of the stored key
    logic [KEY_W:0]    key_mem [SLOT_COUNT];
    logic [VAL_W-1:0]  val_mem [SLOT_COUNT];
    logic [KEY_W:0]    key_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;
    logic              key_we;
    logic [KEY_W:0]    key_wdata;
    logic              val_we;

    logic              req_acc;
    logic              rem_start;
    logic              rem_done;
    logic [IDX_W-1:0]  rem_first;
    logic [IDX_W-1:0]  rem_stride;
    logic [IDX_W:0]    idx_sum;
    logic [IDX_W-1:0]  idx_step;
    logic [CNT_W-1:0]  probe_inc;
    logic              slot_used;
    logic              key_hit;
    logic              rsp_free;

    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // capacity fast path skips hashing entirely
    assign rem_start = req_acc && !(action == dhkv_pkg::ACT_INSERT && count_reg >= SLOTS_CNT);

    dhkv_rem #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_rem (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (rem_start),
        .key        (key),
        .done       (rem_done),
        .rem_first  (rem_first),
        .rem_stride (rem_stride)
    );

    // next probe slot, wraps modulo the slot count
    assign idx_sum   = {1'b0, idx_reg} + {1'b0, stride_reg};
    assign idx_step  = (idx_sum >= SLOTS_EXT) ? IDX_W'(idx_sum - SLOTS_EXT) : IDX_W'(idx_sum);
    assign probe_inc = probe_reg + 1'b1;

    assign slot_used = key_rd_reg[KEY_W];
    assign key_hit   = (key_rd_reg[KEY_W-1:0] == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        stride_next    = stride_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        res_st_next    = res_st_reg;
        res_val_next   = res_val_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        key_we         = 1'b0;
        key_wdata      = {1'b1, key_reg};
        val_we         = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                key_we    = 1'b1;
                key_wdata = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_acc)
                begin
                    act_next = action;
                    key_next = key;
                    val_next = value_in;
                    if (rem_start)
                    begin
                        state_next = S_HASH;
                    end
                    else
                    begin
                        res_st_next  = dhkv_pkg::ST_FULL;
                        res_val_next = '0;
                        state_next   = S_DONE;
                    end
                end
            end
            S_HASH:
            begin
                if (rem_done)
                begin
                    idx_next    = rem_first;
                    stride_next = rem_stride + 1'b1;
                    probe_next  = '0;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                // slot memory latches the read this cycle
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_val_next = '0;
                if (!slot_used)
                begin
                    if (act_reg == dhkv_pkg::ACT_INSERT)
                    begin
                        key_we      = 1'b1;
                        val_we      = 1'b1;
                        count_next  = count_reg + 1'b1;
                        res_st_next = dhkv_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        res_st_next = dhkv_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else if (key_hit)
                begin
                    if (act_reg == dhkv_pkg::ACT_INSERT)
                    begin
                        val_we      = 1'b1;
                        res_st_next = dhkv_pkg::ST_UPDATED;
                    end
                    else
                    begin
                        res_st_next  = dhkv_pkg::ST_FOUND;
                        res_val_next = val_rd_reg;
                    end
                    state_next = S_DONE;
                end
                else if (probe_inc == SLOTS_CNT)
                begin
                    // probe sequence used up
                    res_st_next = (act_reg == dhkv_pkg::ACT_INSERT) ?
                                  dhkv_pkg::ST_FULL : dhkv_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    probe_next = probe_inc;
                    idx_next   = idx_step;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_st_reg;
                    value_out_next = res_val_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            probe_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stride_reg    <= stride_next;
        act_reg       <= act_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        res_st_reg    <= res_st_next;
        res_val_reg   <= res_val_next;
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[idx_reg] <= key_wdata;
        end
        key_rd_reg <= key_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[idx_reg] <= val_reg;
        end
        val_rd_reg <= val_mem[idx_reg];
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

    // entry count never passes the slot count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_CNT)
        else $error("entry count above slot count");

    // a check always follows its memory read
    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> $past(state_reg) == S_READ)
        else $error("slot check without a read");

    // probe address stays inside the table
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_CHECK) |-> idx_reg <= LAST_IDX)
        else $error("probe index out of range");

    // only a found word carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != dhkv_pkg::ST_FOUND) |-> value_out == '0)
        else $error("value on a response that is not found");

    // the count moves only on a new insert
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (status == dhkv_pkg::ST_INSERTED || state_reg == S_DONE))
        else $error("entry count changed without an insert");

endmodule

`default_nettype wire
